>>> hw/rtl/tlb_page_table_translator_assert.svh
// Assertion macros for the translator
`ifndef TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define TPT_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TPT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define TPT_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define TPT_ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

>>> hw/rtl/tpt_pkg.sv
package tpt_pkg;
    localparam int TLB_SLOTS_DEF  = 16;
    localparam int MAX_FRAMES_DEF = 256;
    localparam int PAGE_W  = 8;
    localparam int FRAME_W = 8;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 32;
    localparam int PAGE_COUNT = 256;

    localparam logic [1:0] HIT_TLB   = 2'd0;
    localparam logic [1:0] HIT_TABLE = 2'd1;
    localparam logic [1:0] HIT_FAULT = 2'd2;

    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_FRAMES = 1'b1;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [7:0]        offset;
    } req_t;

    typedef struct packed {
        logic [15:0]        physical_address;
        logic [1:0]         hit_class;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [CNT_W-1:0]   tlb_hit_total;
        logic [CNT_W-1:0]   table_hit_total;
        logic [CNT_W-1:0]   fault_total;
    } res_t;
endpackage

>>> hw/rtl/tpt_ram.sv
module tpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hw/rtl/tpt_front.sv
module tpt_front import tpt_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [15:0]       logical_address,
    output logic              q_valid,
    input  logic              q_take,
    output req_t              q_req
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    req_t            buf_reg [DEPTH];
    logic [AW-1:0]   wr_reg, rd_reg;
    logic [AW:0]     cnt_reg;
    logic            push, pop;

    assign in_stall = (cnt_reg == (AW+1)'(DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_valid && q_take;
    assign q_req    = buf_reg[rd_reg];

    // split the address into page and offset on entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_reg] <= '{page: logical_address[15:8], offset: logical_address[7:0]};
        end
    end

    // advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH-1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH-1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

>>> hw/rtl/tpt_back.sv
`include "tlb_page_table_translator_assert.svh"
module tpt_back import tpt_pkg::*; #(
    parameter int TLB_SLOTS  = TLB_SLOTS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode,
    input  logic [8:0] frames_cfg,
    input  logic       q_valid,
    output logic       q_take,
    input  req_t       q_req,
    output logic       res_valid,
    input  logic       res_take,
    output res_t       res
);
    localparam int TW = (TLB_SLOTS > 1) ? $clog2(TLB_SLOTS) : 1;
    localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_TABLE, S_TWAIT, S_FREE, S_FWAIT, S_LRU, S_LRUW, S_EVICT,
        S_EVWAIT, S_FILL, S_TLRU, S_DONE
    } state_t;

    state_t state_reg;

    // TLB in flip-flops (TLB_SLOTS entries, 16 by default, matched in parallel)
    logic [TLB_SLOTS-1:0] tv_reg;
    logic [PAGE_W-1:0]    tp_reg [TLB_SLOTS];
    logic [FRAME_W-1:0]   tf_reg [TLB_SLOTS];
    logic [STAMP_W-1:0]   ts_reg [TLB_SLOTS];
    logic [TW-1:0]        tptr_reg;

    logic [PAGE_COUNT-1:0] pv_reg;
    logic [MAX_FRAMES-1:0] fu_reg;
    logic [FW-1:0]         fptr_reg;

    logic [STAMP_W-1:0] clk_cnt_reg;
    logic [CNT_W-1:0]   ct_reg, cp_reg, cf_reg;

    req_t               req_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [FW:0]        idx_reg;
    logic [FW:0]        n_frames;
    logic [FW:0]        victim_reg;
    logic [STAMP_W-1:0] best_reg;
    logic               ev_reg;
    logic [PAGE_W-1:0]  evp_reg;

    // TLB victim scan under LRU
    logic [TW-1:0]      tidx_reg;
    logic [TW-1:0]      tvic_reg;
    logic [STAMP_W-1:0] tbest_reg;
    logic               tdone_reg;

    // TLB match
    logic [TLB_SLOTS-1:0] hit_vec;
    logic [TW-1:0]        hit_idx;
    logic                 hit_any;
    logic [TLB_SLOTS-1:0] empty_vec;
    logic [TW-1:0]        empty_idx;

    always_comb
    begin
        hit_any   = 1'b0;
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = TLB_SLOTS-1; i >= 0; i--)
        begin
            hit_vec[i]   = tv_reg[i] && (tp_reg[i] == req_reg.page);
            empty_vec[i] = !tv_reg[i];
            if (hit_vec[i])
            begin
                hit_any = 1'b1;
                hit_idx = TW'(i);
            end
            if (empty_vec[i])
            begin
                empty_idx = TW'(i);
            end
        end
    end

    // clamp the frame count
    always_comb
    begin
        if (frames_cfg == 9'd0)
        begin
            n_frames = (FW+1)'(1);
        end
        else if ({1'b0, frames_cfg} > 10'(MAX_FRAMES))
        begin
            n_frames = (FW+1)'(MAX_FRAMES);
        end
        else
        begin
            n_frames = (FW+1)'(frames_cfg);
        end
    end

    // memories: page table frames, frame owners, frame stamps
    logic               pt_we, fo_we, fs_we;
    logic [PAGE_W-1:0]  pt_wa, pt_ra;
    logic [FRAME_W-1:0] pt_wd, pt_rd;
    logic [FW-1:0]      fo_wa, fo_ra, fs_wa, fs_ra;
    logic [PAGE_W-1:0]  fo_wd, fo_rd;
    logic [STAMP_W-1:0] fs_wd, fs_rd;

    tpt_ram #(.WIDTH(FRAME_W), .DEPTH(PAGE_COUNT)) u_pt (
        .clk(clk), .we(pt_we), .waddr(pt_wa), .wdata(pt_wd), .raddr(pt_ra), .rdata(pt_rd)
    );
    tpt_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_FRAMES)) u_fo (
        .clk(clk), .we(fo_we), .waddr(fo_wa), .wdata(fo_wd), .raddr(fo_ra), .rdata(fo_rd)
    );
    tpt_ram #(.WIDTH(STAMP_W), .DEPTH(MAX_FRAMES)) u_fs (
        .clk(clk), .we(fs_we), .waddr(fs_wa), .wdata(fs_wd), .raddr(fs_ra), .rdata(fs_rd)
    );

    logic [FW-1:0] vic_fw;
    assign vic_fw = victim_reg[FW-1:0];

    assign pt_ra = req_reg.page;
    assign fo_ra = vic_fw;
    assign fs_ra = idx_reg[FW-1:0];

    // write ports are used in the commit steps only
    always_comb
    begin
        pt_we = 1'b0;
        pt_wa = req_reg.page;
        pt_wd = frame_reg;
        fo_we = 1'b0;
        fo_wa = frame_reg[FW-1:0];
        fo_wd = req_reg.page;
        fs_we = 1'b0;
        fs_wa = frame_reg[FW-1:0];
        fs_wd = clk_cnt_reg;
        if (state_reg == S_FILL)
        begin
            pt_we = 1'b1;
            fo_we = 1'b1;
        end
        if (state_reg == S_DONE && !res_valid)
        begin
            fs_we = ({1'b0, frame_reg} < 9'(MAX_FRAMES));
        end
    end

    assign q_take = (state_reg == S_IDLE) && !res_valid;

    always_ff @(posedge clk)
    begin
        if (q_take && q_valid)
        begin
            req_reg <= q_req;
        end
    end

    // sequencer: lookup, fault handling, commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            tv_reg      <= '0;
            pv_reg      <= '0;
            fu_reg      <= '0;
            tptr_reg    <= '0;
            fptr_reg    <= '0;
            clk_cnt_reg <= '0;
            ct_reg      <= '0;
            cp_reg      <= '0;
            cf_reg      <= '0;
            res_valid   <= 1'b0;
            ev_reg      <= 1'b0;
            evp_reg     <= '0;
            frame_reg   <= '0;
            idx_reg     <= '0;
            victim_reg  <= '0;
            best_reg    <= '0;
            tidx_reg    <= '0;
            tvic_reg    <= '0;
            tbest_reg   <= '0;
            tdone_reg   <= 1'b0;
            res         <= '0;
        end
        else
        begin
            if (res_valid && res_take)
            begin
                res_valid <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_take && q_valid)
                    begin
                        state_reg <= S_TABLE;
                    end
                end
                S_TABLE:
                begin
                    ev_reg    <= 1'b0;
                    evp_reg   <= '0;
                    tdone_reg <= 1'b0;
                    if (hit_any)
                    begin
                        frame_reg       <= tf_reg[hit_idx];
                        ts_reg[hit_idx] <= clk_cnt_reg;
                        ct_reg          <= ct_reg + 1'b1;
                        res.hit_class   <= HIT_TLB;
                        state_reg       <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_TWAIT;
                    end
                end
                S_TWAIT:
                begin
                    if (pv_reg[req_reg.page])
                    begin
                        frame_reg     <= pt_rd;
                        cp_reg        <= cp_reg + 1'b1;
                        res.hit_class <= HIT_TABLE;
                        state_reg     <= S_DONE;
                    end
                    else
                    begin
                        res.hit_class <= HIT_FAULT;
                        idx_reg       <= '0;
                        state_reg     <= S_FREE;
                    end
                end
                S_FREE:
                begin
                    // scan for the first free frame, one per cycle
                    if (idx_reg >= n_frames)
                    begin
                        ev_reg <= 1'b1;
                        if (!mode)
                        begin
                            if ({1'b0, fptr_reg} < n_frames)
                            begin
                                victim_reg <= {1'b0, fptr_reg};
                                fptr_reg   <= (({1'b0, fptr_reg} + 1'b1) == n_frames)
                                              ? '0 : fptr_reg + 1'b1;
                            end
                            else
                            begin
                                victim_reg <= '0;
                                fptr_reg   <= (n_frames == (FW+1)'(1)) ? '0 : FW'(1);
                            end
                            state_reg <= S_EVICT;
                        end
                        else
                        begin
                            idx_reg    <= '0;
                            victim_reg <= '0;
                            state_reg  <= S_LRU;
                        end
                    end
                    else if (!fu_reg[idx_reg[FW-1:0]])
                    begin
                        frame_reg <= FRAME_W'(idx_reg);
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_LRU:
                begin
                    state_reg <= S_LRUW;
                end
                S_LRUW:
                begin
                    // stamp of frame idx_reg is on the read port
                    if (idx_reg == '0 || (clk_cnt_reg - fs_rd) > best_reg)
                    begin
                        best_reg   <= clk_cnt_reg - fs_rd;
                        victim_reg <= idx_reg;
                    end
                    if ((idx_reg + 1'b1) == n_frames)
                    begin
                        state_reg <= S_EVICT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_LRU;
                    end
                end
                S_EVICT:
                begin
                    state_reg <= S_EVWAIT;
                end
                S_EVWAIT:
                begin
                    evp_reg            <= fo_rd;
                    frame_reg          <= FRAME_W'(victim_reg);
                    pv_reg[fo_rd]      <= 1'b0;
                    for (int i = 0; i < TLB_SLOTS; i++)
                    begin
                        if (tp_reg[i] == fo_rd)
                        begin
                            tv_reg[i] <= 1'b0;
                        end
                    end
                    state_reg <= S_FILL;
                end
                S_FILL:
                begin
                    if (mode && empty_vec == '0 && !tdone_reg)
                    begin
                        // full TLB under LRU: find the oldest slot first
                        tidx_reg  <= '0;
                        state_reg <= S_TLRU;
                    end
                    else
                    begin
                        fu_reg[frame_reg[FW-1:0]] <= 1'b1;
                        pv_reg[req_reg.page]      <= 1'b1;
                        if (empty_vec != '0)
                        begin
                            tv_reg[empty_idx] <= 1'b1;
                            tp_reg[empty_idx] <= req_reg.page;
                            tf_reg[empty_idx] <= frame_reg;
                            ts_reg[empty_idx] <= clk_cnt_reg;
                        end
                        else if (!mode)
                        begin
                            tp_reg[tptr_reg] <= req_reg.page;
                            tf_reg[tptr_reg] <= frame_reg;
                            ts_reg[tptr_reg] <= clk_cnt_reg;
                            tptr_reg <= (tptr_reg == TW'(TLB_SLOTS-1)) ? '0 : tptr_reg + 1'b1;
                        end
                        else
                        begin
                            tp_reg[tvic_reg] <= req_reg.page;
                            tf_reg[tvic_reg] <= frame_reg;
                            ts_reg[tvic_reg] <= clk_cnt_reg;
                        end
                        tdone_reg <= 1'b0;
                        cf_reg    <= cf_reg + 1'b1;
                        state_reg <= S_DONE;
                    end
                end
                S_TLRU:
                begin
                    // oldest TLB slot, lowest index on ties, one slot per cycle
                    if (tidx_reg == '0 || (clk_cnt_reg - ts_reg[tidx_reg]) > tbest_reg)
                    begin
                        tbest_reg <= clk_cnt_reg - ts_reg[tidx_reg];
                        tvic_reg  <= tidx_reg;
                    end
                    if (tidx_reg == TW'(TLB_SLOTS-1))
                    begin
                        tdone_reg <= 1'b1;
                        state_reg <= S_FILL;
                    end
                    else
                    begin
                        tidx_reg <= tidx_reg + 1'b1;
                    end
                end
                S_DONE:
                begin
                    if (!res_valid)
                    begin
                        res.physical_address <= {frame_reg, req_reg.offset};
                        res.evicted_valid    <= ev_reg;
                        res.evicted_page     <= evp_reg;
                        res.tlb_hit_total    <= ct_reg;
                        res.table_hit_total  <= cp_reg;
                        res.fault_total      <= cf_reg;
                        res_valid            <= 1'b1;
                        clk_cnt_reg          <= clk_cnt_reg + 1'b1;
                        state_reg            <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `TPT_ASSERT_IMPL(a_take_idle, clk, rst_n, q_take |-> (state_reg == S_IDLE), "take outside idle")
    `TPT_ASSERT_NEXT(a_done_out, clk, rst_n, (state_reg == S_DONE && !res_valid), res_valid, "result lost")
    `TPT_ASSERT_IMPL(a_no_evict_hit, clk, rst_n, (res_valid && res.hit_class != HIT_FAULT) |-> !res.evicted_valid, "evict on hit")
endmodule

>>> hw/rtl/tlb_page_table_translator.sv
// Steps: TLB hit IDLE, TABLE, DONE; page-table hit adds TWAIT; a fault adds
// the free-frame scan (FREE) and FILL, an eviction EVICT and EVWAIT, LRU a scan
// of every usable frame (LRU, LRUW), a full TLB under LRU a slot scan (TLRU).
// One item at a time; the frame scan sets the fault rate.
// Reset (rst_n, async low) clears TLB, table and frame valid bits, pointers,
// access clock and counters; no clearing pass is needed.
module tlb_page_table_translator import tpt_pkg::*; #(
    parameter int TLB_SLOTS  = TLB_SLOTS_DEF,
    parameter int MAX_FRAMES = MAX_FRAMES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [8:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] logical_address,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] physical_address,
    output logic [1:0]  hit_class,
    output logic        evicted_valid,
    output logic [7:0]  evicted_page,
    output logic [31:0] tlb_hit_total,
    output logic [31:0] table_hit_total,
    output logic [31:0] fault_total
);
    logic       mode_reg;
    logic [8:0] frames_reg;
    logic       q_valid, q_take;
    req_t       q_req;
    res_t       res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            frames_reg <= 9'd256;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MODE)
            begin
                mode_reg <= cfg_data[0];
            end
            else
            begin
                frames_reg <= cfg_data;
            end
        end
    end

    tpt_front #(.DEPTH(2)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .logical_address(logical_address), .q_valid(q_valid), .q_take(q_take), .q_req(q_req)
    );

    tpt_back #(.TLB_SLOTS(TLB_SLOTS), .MAX_FRAMES(MAX_FRAMES)) u_back (
        .clk(clk), .rst_n(rst_n), .mode(mode_reg), .frames_cfg(frames_reg),
        .q_valid(q_valid), .q_take(q_take), .q_req(q_req),
        .res_valid(out_valid), .res_take(!out_stall), .res(res)
    );

    assign physical_address = res.physical_address;
    assign hit_class        = res.hit_class;
    assign evicted_valid    = res.evicted_valid;
    assign evicted_page     = res.evicted_page;
    assign tlb_hit_total    = res.tlb_hit_total;
    assign table_hit_total  = res.table_hit_total;
    assign fault_total      = res.fault_total;
endmodule
